### design/cdd_pkg.sv
`default_nettype none

package cdd_pkg;

    localparam int unsigned DAY_W   = 16;
    localparam int unsigned CENT_W  = 7;
    localparam int unsigned YEAR_W  = 7;
    localparam int unsigned MONTH_W = 4;
    localparam int unsigned MDAY_W  = 5;
    localparam int unsigned PACK_W  = 27;
    localparam int unsigned YLEN_W  = 9;
    localparam int unsigned PC_W    = 3;
    localparam int unsigned UCODE_DEPTH = 8;

    localparam logic [DAY_W-1:0]   CENTURY_DAYS = 16'd36524;
    localparam logic [YLEN_W-1:0]  YEAR_DAYS    = 9'd365;
    localparam logic [YEAR_W-1:0]  LAST_YEAR    = 7'd99;
    localparam logic [MONTH_W-1:0] LAST_MONTH   = 4'd12;
    localparam logic [MDAY_W-1:0]  LAST_MDAY    = 5'd31;
    localparam logic [6:0]         DEC_SCALE    = 7'd100;

    typedef logic [2:0] t_op;
    localparam t_op OP_IDLE  = 3'd0;
    localparam t_op OP_CHECK = 3'd1;
    localparam t_op OP_YEAR  = 3'd2;
    localparam t_op OP_MONTH = 3'd3;
    localparam t_op OP_MUL_Y = 3'd4;
    localparam t_op OP_MUL_M = 3'd5;
    localparam t_op OP_MUL_D = 3'd6;
    localparam t_op OP_DONE  = 3'd7;

    typedef logic [1:0] t_jmp;
    localparam t_jmp JMP_NONE  = 2'd0;
    localparam t_jmp JMP_TRUE  = 2'd1;
    localparam t_jmp JMP_FALSE = 2'd2;

    typedef logic [PC_W-1:0] t_pc;
    localparam t_pc PC_IDLE  = 3'd0;
    localparam t_pc PC_CHECK = 3'd1;
    localparam t_pc PC_YEAR  = 3'd2;
    localparam t_pc PC_MONTH = 3'd3;
    localparam t_pc PC_MUL_Y = 3'd4;
    localparam t_pc PC_MUL_M = 3'd5;
    localparam t_pc PC_MUL_D = 3'd6;
    localparam t_pc PC_DONE  = 3'd7;

    typedef struct packed {
        t_op  op;
        t_jmp jmp;
        t_pc  target;
    } t_uword;

    typedef struct packed {
        logic cond;
    } t_stat;

    // step after the last one wraps to idle
    localparam t_uword UCODE [UCODE_DEPTH] = '{
        '{op: OP_IDLE,  jmp: JMP_FALSE, target: PC_IDLE},
        '{op: OP_CHECK, jmp: JMP_TRUE,  target: PC_MUL_Y},
        '{op: OP_YEAR,  jmp: JMP_TRUE,  target: PC_YEAR},
        '{op: OP_MONTH, jmp: JMP_TRUE,  target: PC_MONTH},
        '{op: OP_MUL_Y, jmp: JMP_NONE,  target: PC_IDLE},
        '{op: OP_MUL_M, jmp: JMP_NONE,  target: PC_IDLE},
        '{op: OP_MUL_D, jmp: JMP_NONE,  target: PC_IDLE},
        '{op: OP_DONE,  jmp: JMP_FALSE, target: PC_DONE}
    };

    function automatic logic [MDAY_W-1:0] month_len(input logic [MONTH_W-1:0] month,
                                                    input logic leap);
        logic [MDAY_W-1:0] len;
        case (month)
            4'd2:                      len = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
            default:                   len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

`default_nettype wire

### design/century_days_to_date_top.sv
`default_nettype none

// channel   | dir | tdata (low bit up)                               | tuser
// s_axis    | in  | day_count[15:0], century[22:16], zero pad        | -
// m_axis    | out | packed_date[26:0], year_in_century[33:27],       | out_of_range
//           |     | month_number[37:34], day_of_month[42:38], pad     |
//
// For each accepted item the sequencer runs a range check, one step per whole
// year removed (up to 99), one per month removed (up to 11), the year and month
// exit steps, three multiply-by-100 steps and handoff; an out-of-range count
// skips both loops. Handoff holds while the output register stays full.
// Synchronous active-low reset returns the step counter to idle, empties the
// output register and holds s_axis_tready low. A new item is taken once the
// result sits in the output register, even while m_axis stalls.

module century_days_to_date_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [23:0] i_s_axis_tdata,   // day_count, century
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic [47:0]      o_m_axis_tdata,   // packed_date, year, month, day
    output logic             o_m_axis_tuser    // out_of_range
);

    cdd_pkg::t_uword w_uword;
    cdd_pkg::t_stat  w_stat;

    logic                            w_start;
    logic                            w_out_free;
    logic                            w_load;
    logic [cdd_pkg::PACK_W-1:0]      w_packed;
    logic [cdd_pkg::YEAR_W-1:0]      w_year;
    logic [cdd_pkg::MONTH_W-1:0]     w_month;
    logic [cdd_pkg::MDAY_W-1:0]      w_mday;
    logic                            w_flag;

    logic        r_m_valid;
    logic [47:0] r_m_data;
    logic        r_m_user;

    assign o_s_axis_tready = i_rst_n && (w_uword.op == cdd_pkg::OP_IDLE);
    assign w_start    = i_s_axis_tvalid && o_s_axis_tready;
    assign w_out_free = !r_m_valid || i_m_axis_tready;
    assign w_load     = (w_uword.op == cdd_pkg::OP_DONE) && w_out_free;

    cdd_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (w_stat),
        .o_uword (w_uword)
    );

    cdd_dp u_dp (
        .i_clk         (i_clk),
        .i_uword       (w_uword),
        .i_start       (w_start),
        .i_out_free    (w_out_free),
        .i_day_count   (i_s_axis_tdata[15:0]),
        .i_century     (i_s_axis_tdata[22:16]),
        .o_stat        (w_stat),
        .o_packed_date (w_packed),
        .o_year        (w_year),
        .o_month       (w_month),
        .o_mday        (w_mday),
        .o_flag        (w_flag)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (w_load) begin
            r_m_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_m_data <= {5'b0, w_mday, w_month, w_year, w_packed};
            r_m_user <= w_flag;
        end
    end

    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tdata  = r_m_data;
    assign o_m_axis_tuser  = r_m_user;

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready |=> !o_s_axis_tready)
        else $error("input taken twice in a row");

    a_month_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tdata[37:34] != 4'd0) && (o_m_axis_tdata[37:34] <= 4'd12))
        else $error("month out of range");

    a_day_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !o_m_axis_tuser |-> o_m_axis_tdata[42:38] != 5'd0)
        else $error("day zero without flag");

    a_year_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> o_m_axis_tdata[33:27] <= 7'd99)
        else $error("year out of range");

endmodule

`default_nettype wire

### design/cdd_seq.sv
`default_nettype none

module cdd_seq (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire cdd_pkg::t_stat i_stat,
    output cdd_pkg::t_uword     o_uword
);

    cdd_pkg::t_pc r_pc;
    cdd_pkg::t_pc n_pc;
    cdd_pkg::t_uword w_uword;

    assign w_uword = cdd_pkg::UCODE[r_pc];
    assign o_uword = w_uword;

    always_comb begin
        n_pc = r_pc + 1'b1;
        unique case (w_uword.jmp)
            cdd_pkg::JMP_TRUE:  if (i_stat.cond) n_pc = w_uword.target;
            cdd_pkg::JMP_FALSE: if (!i_stat.cond) n_pc = w_uword.target;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= cdd_pkg::PC_IDLE;
        end else begin
            r_pc <= n_pc;
        end
    end

endmodule

`default_nettype wire

### design/cdd_dp.sv
`default_nettype none

module cdd_dp (
    input  wire logic                          i_clk,
    input  wire cdd_pkg::t_uword               i_uword,
    input  wire logic                          i_start,
    input  wire logic                          i_out_free,
    input  wire logic [cdd_pkg::DAY_W-1:0]     i_day_count,
    input  wire logic [cdd_pkg::CENT_W-1:0]    i_century,
    output cdd_pkg::t_stat                     o_stat,
    output logic [cdd_pkg::PACK_W-1:0]         o_packed_date,
    output logic [cdd_pkg::YEAR_W-1:0]         o_year,
    output logic [cdd_pkg::MONTH_W-1:0]        o_month,
    output logic [cdd_pkg::MDAY_W-1:0]         o_mday,
    output logic                               o_flag
);

    logic [cdd_pkg::DAY_W-1:0]   r_day,   n_day;
    logic [cdd_pkg::CENT_W-1:0]  r_cent,  n_cent;
    logic [cdd_pkg::YEAR_W-1:0]  r_year,  n_year;
    logic [cdd_pkg::MONTH_W-1:0] r_month, n_month;
    logic                        r_flag,  n_flag;
    logic [cdd_pkg::PACK_W-1:0]  r_acc,   n_acc;

    logic                        w_cent_leap;
    logic                        w_leap;
    logic [cdd_pkg::DAY_W-1:0]   w_total;
    logic [cdd_pkg::YLEN_W-1:0]  w_ylen;
    logic [cdd_pkg::MDAY_W-1:0]  w_mlen;
    logic                        w_sat;
    logic                        w_year_loop;
    logic                        w_month_loop;

    assign w_cent_leap = (r_cent[1:0] == 2'b00);
    assign w_leap      = (r_year == '0) ? w_cent_leap : (r_year[1:0] == 2'b00);
    assign w_total     = cdd_pkg::CENTURY_DAYS + cdd_pkg::DAY_W'(w_cent_leap);
    assign w_ylen      = cdd_pkg::YEAR_DAYS + cdd_pkg::YLEN_W'(w_leap);
    assign w_mlen      = cdd_pkg::month_len(r_month, w_leap);
    assign w_sat       = (r_day > w_total);
    assign w_year_loop = (r_day > cdd_pkg::DAY_W'(w_ylen)) && (r_year < cdd_pkg::LAST_YEAR);
    assign w_month_loop = (r_day > cdd_pkg::DAY_W'(w_mlen)) && (r_month < cdd_pkg::LAST_MONTH);

    always_comb begin
        n_day   = r_day;
        n_cent  = r_cent;
        n_year  = r_year;
        n_month = r_month;
        n_flag  = r_flag;
        n_acc   = r_acc;
        o_stat.cond = 1'b0;
        unique case (i_uword.op)
            cdd_pkg::OP_IDLE: begin
                o_stat.cond = i_start;
                if (i_start) begin
                    n_day   = i_day_count;
                    n_cent  = i_century;
                    n_year  = '0;
                    n_month = cdd_pkg::MONTH_W'(1);
                    n_flag  = (i_day_count == '0);
                end
            end
            cdd_pkg::OP_CHECK: begin
                o_stat.cond = w_sat;
                if (w_sat) begin
                    n_day   = cdd_pkg::DAY_W'(cdd_pkg::LAST_MDAY);
                    n_year  = cdd_pkg::LAST_YEAR;
                    n_month = cdd_pkg::LAST_MONTH;
                    n_flag  = 1'b1;
                end
            end
            cdd_pkg::OP_YEAR: begin
                o_stat.cond = w_year_loop;
                if (w_year_loop) begin
                    n_day  = r_day - cdd_pkg::DAY_W'(w_ylen);
                    n_year = r_year + 1'b1;
                end
            end
            cdd_pkg::OP_MONTH: begin
                o_stat.cond = w_month_loop;
                if (w_month_loop) begin
                    n_day   = r_day - cdd_pkg::DAY_W'(w_mlen);
                    n_month = r_month + 1'b1;
                end
            end
            cdd_pkg::OP_MUL_Y: begin
                n_acc = cdd_pkg::PACK_W'(r_cent) * cdd_pkg::PACK_W'(cdd_pkg::DEC_SCALE)
                      + cdd_pkg::PACK_W'(r_year);
            end
            cdd_pkg::OP_MUL_M: begin
                n_acc = cdd_pkg::PACK_W'(r_acc * cdd_pkg::DEC_SCALE)
                      + cdd_pkg::PACK_W'(r_month);
            end
            cdd_pkg::OP_MUL_D: begin
                n_acc = cdd_pkg::PACK_W'(r_acc * cdd_pkg::DEC_SCALE)
                      + cdd_pkg::PACK_W'(r_day);
            end
            cdd_pkg::OP_DONE: begin
                o_stat.cond = i_out_free;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_day   <= n_day;
        r_cent  <= n_cent;
        r_year  <= n_year;
        r_month <= n_month;
        r_flag  <= n_flag;
        r_acc   <= n_acc;
    end

    assign o_packed_date = r_acc;
    assign o_year        = r_year;
    assign o_month       = r_month;
    assign o_mday        = r_day[cdd_pkg::MDAY_W-1:0];
    assign o_flag        = r_flag;

endmodule

`default_nettype wire

### tb/testbench.sv
`timescale 1ns / 100ps

module testbench;

    localparam int unsigned HOLD_CYCLES = 400;
    localparam int unsigned QUIET_LIMIT = 4000;
    localparam int unsigned DRAIN_CYCLES = 150;
    localparam int unsigned MAX_REPORTS = 10;

    typedef struct packed {
        logic [cdd_pkg::PACK_W-1:0]  packed_date;
        logic [cdd_pkg::YEAR_W-1:0]  year;
        logic [cdd_pkg::MONTH_W-1:0] month;
        logic [cdd_pkg::MDAY_W-1:0]  mday;
        logic                        bad;
    } t_date;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        send_valid = 1'b0;
    logic [23:0] send_data = '0;
    logic        recv_ready = 1'b0;
    logic        steady = 1'b0;
    logic        hold_go = 1'b0;
    int unsigned hold_left = 0;
    int unsigned quiet = 0;
    int unsigned errors = 0;
    t_date       date_q[$];

    wire         o_s_axis_tready;
    wire         o_m_axis_tvalid;
    wire [47:0]  o_m_axis_tdata;
    wire         o_m_axis_tuser;

    century_days_to_date_top u_top (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (send_valid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (send_data),       // day_count[15:0], century[22:16], pad
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (recv_ready),
        .o_m_axis_tdata  (o_m_axis_tdata),  // packed_date, year, month, day, pad
        .o_m_axis_tuser  (o_m_axis_tuser)   // out_of_range
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic bit leap_year(int unsigned yr, int unsigned cent);
        return (yr == 0) ? (cent % 4 == 0) : (yr % 4 == 0);
    endfunction

    function automatic t_date predict_date(logic [cdd_pkg::DAY_W-1:0] days,
                                           logic [cdd_pkg::CENT_W-1:0] cent);
        int unsigned d, c, yr, mo, ylen, mlen;
        t_date r;
        d = days;
        c = cent;
        yr = 0;
        mo = 1;
        r.bad = (d == 0);
        if (d > cdd_pkg::CENTURY_DAYS + ((c % 4 == 0) ? 1 : 0)) begin
            r.bad = 1'b1;
            yr = 99;
            mo = 12;
            d = 31;
        end else begin
            ylen = leap_year(0, c) ? cdd_pkg::YEAR_DAYS + 1 : cdd_pkg::YEAR_DAYS;
            while (d > ylen && yr < 99) begin
                d -= ylen;
                yr++;
                ylen = leap_year(yr, c) ? cdd_pkg::YEAR_DAYS + 1 : cdd_pkg::YEAR_DAYS;
            end
            for (mo = 1; mo < 12; mo++) begin
                case (mo)
                    2:         mlen = leap_year(yr, c) ? 29 : 28;
                    4, 6, 9, 11: mlen = 30;
                    default:   mlen = 31;
                endcase
                if (d <= mlen) break;
                d -= mlen;
            end
        end
        r.packed_date = cdd_pkg::PACK_W'(((c * 100 + yr) * 100 + mo) * 100 + d);
        r.year = cdd_pkg::YEAR_W'(yr);
        r.month = cdd_pkg::MONTH_W'(mo);
        r.mday = cdd_pkg::MDAY_W'(d);
        return r;
    endfunction

    function automatic void report_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            errors++;
            if (errors <= MAX_REPORTS)
                $display("mismatch %s: expected %0d, got %0d at %0t", name, want, got, $realtime);
        end
    endfunction

    function automatic void check_date(logic [47:0] tdata, logic tuser);
        t_date want;
        if (date_q.size() == 0) begin
            errors++;
            if (errors <= MAX_REPORTS)
                $display("unexpected result tdata=%h tuser=%b at %0t", tdata, tuser, $realtime);
            return;
        end
        want = date_q.pop_front();
        report_field("packed_date", want.packed_date, tdata[26:0]);
        report_field("year", want.year, tdata[33:27]);
        report_field("month", want.month, tdata[37:34]);
        report_field("day", want.mday, tdata[42:38]);
        report_field("out_of_range", want.bad, tuser);
    endfunction

    always @(posedge clk) begin
        if (hold_go) begin
            hold_left <= HOLD_CYCLES;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    always @(posedge clk) begin
        if (!rst_n) begin
            recv_ready <= 1'b0;
        end else begin
            if (o_m_axis_tvalid && recv_ready) check_date(o_m_axis_tdata, o_m_axis_tuser);
            recv_ready <= (hold_left == 0) && !hold_go && (steady || $urandom_range(99) >= 33);
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (send_valid && o_s_axis_tready) || (o_m_axis_tvalid && recv_ready)) begin
            quiet <= 0;
        end else begin
            quiet <= quiet + 1;
            if (quiet == QUIET_LIMIT) begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    task automatic send_item(logic [cdd_pkg::DAY_W-1:0] days,
                             logic [cdd_pkg::CENT_W-1:0] cent);
        if (!steady) begin
            while ($urandom_range(99) < 33) begin
                send_valid <= 1'b0;
                @(posedge clk);
            end
        end
        send_valid <= 1'b1;
        send_data <= {1'b0, cent, days};
        do @(posedge clk); while (!o_s_axis_tready);
        date_q.push_back(predict_date(days, cent));
    endtask

    task automatic send_random_date();
        int unsigned cent, last_day, pick;
        logic [cdd_pkg::DAY_W-1:0] days;
        cent = ($urandom_range(99) < 5) ? $urandom_range(127, 100) : $urandom_range(99, 0);
        last_day = cdd_pkg::CENTURY_DAYS + ((cent % 4 == 0) ? 1 : 0);
        pick = $urandom_range(99);
        if (pick < 6)
            days = '0;
        else if (pick < 14)
            days = cdd_pkg::DAY_W'($urandom_range(65535, last_day + 1));
        else if (pick < 24)
            days = cdd_pkg::DAY_W'($urandom_range(400, 1));
        else
            days = cdd_pkg::DAY_W'($urandom_range(last_day, 1));
        send_item(days, cdd_pkg::CENT_W'(cent));
    endtask

    task automatic test_directed();
        send_item(16'd0, 7'd19);
        send_item(16'd0, 7'd20);
        send_item(16'd1, 7'd0);
        send_item(16'd31, 7'd19);
        send_item(16'd32, 7'd19);
        send_item(16'd59, 7'd19);
        send_item(16'd60, 7'd19);
        send_item(16'd60, 7'd20);
        send_item(16'd61, 7'd20);
        send_item(16'd365, 7'd19);
        send_item(16'd366, 7'd19);
        send_item(16'd366, 7'd20);
        send_item(16'd367, 7'd20);
        send_item(16'd1520, 7'd19);
        send_item(16'd1521, 7'd19);
        send_item(16'd36524, 7'd19);
        send_item(16'd36525, 7'd19);
        send_item(16'd36525, 7'd20);
        send_item(16'd36526, 7'd20);
        send_item(16'd65535, 7'd0);
        send_item(16'd65535, 7'd127);
        send_item(16'd12345, 7'd100);
        send_item(16'd36525, 7'd124);
        send_item(16'h8000, 7'd99);
    endtask

    task automatic test_random_dates(int unsigned count);
        repeat (count) send_random_date();
    endtask

    task automatic test_steady_stream(int unsigned count);
        steady <= 1'b1;
        repeat (count) send_random_date();
        steady <= 1'b0;
    endtask

    task automatic test_backpressure(int unsigned count);
        hold_go <= 1'b1;
        @(posedge clk);
        hold_go <= 1'b0;
        repeat (count) send_random_date();
    endtask

    initial begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random_dates(480);
        test_steady_stream(150);
        test_backpressure(40);
        test_random_dates(60);
        send_valid <= 1'b0;
        while (date_q.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
